>>> hw/rtl/length_prefixed_stream_deframer_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef LENGTH_PREFIXED_STREAM_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_STREAM_DEFRAMER_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define LPSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define LPSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

>>> hw/rtl/lpsd_pkg.sv
// Shared types and constants of the length-prefixed stream deframer.
`timescale 1ns / 1ps
`default_nettype none
package lpsd_pkg;

  localparam logic [31:0] HDR_BYTES     = 32'd4;
  localparam logic [1:0]  HDR_LAST_IDX  = 2'd3;
  localparam logic [7:0]  LINE_END      = 8'h0a;
  localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

  localparam logic PHASE_HEADER  = 1'b0;
  localparam logic PHASE_PAYLOAD = 1'b1;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_BINARY_MODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN     = 8'd1;

  // Result kinds carried through the queue.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } entry_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;
  } cfg_wr_t;

endpackage
`default_nettype wire

>>> hw/rtl/lpsd_front.sv
// Front end: configuration registers and byte classification into result entries.
`timescale 1ns / 1ps
`default_nettype none
module lpsd_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_accept,
  input  wire  [7:0]           in_byte,
  input  lpsd_pkg::cfg_wr_t    cfg,
  output logic                 res_valid,
  output lpsd_pkg::entry_t     res
);
  import lpsd_pkg::*;

  logic        mode_r,  mode_nxt;
  logic [15:0] max_r,   max_nxt;
  logic        phase_r, phase_nxt;
  logic [1:0]  cnt_r,   cnt_nxt;
  logic [23:0] acc_r,   acc_nxt;
  logic [15:0] left_r,  left_nxt;
  logic        err_r,   err_nxt;

  logic [31:0] acc_full;
  logic [15:0] left_dec;

  assign acc_full = {acc_r, in_byte};
  assign left_dec = left_r - 16'd1;

  always_comb begin
    mode_nxt  = mode_r;
    max_nxt   = max_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    left_nxt  = left_r;
    err_nxt   = err_r;
    res_valid = 1'b0;
    res       = '0;

    if (in_accept && !err_r) begin
      if (!mode_r) begin
        res_valid = 1'b1;
        res.kind  = KIND_DATA;
        res.data  = in_byte;
        res.last  = (in_byte == LINE_END);
      end else if (phase_r == PHASE_PAYLOAD) begin
        res_valid = 1'b1;
        res.kind  = KIND_DATA;
        res.data  = in_byte;
        res.last  = (left_dec == 16'd0);
        left_nxt  = left_dec;
        if (left_dec == 16'd0) begin
          phase_nxt = PHASE_HEADER;
        end
      end else begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r != HDR_LAST_IDX) begin
          acc_nxt = acc_full[23:0];
        end else begin
          acc_nxt = '0;
          if ((acc_full > {16'd0, max_r}) || (acc_full < HDR_BYTES)) begin
            err_nxt   = 1'b1;
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
          end else if (acc_full == HDR_BYTES) begin
            res_valid = 1'b1;
            res.kind  = KIND_EMPTY;
            res.last  = 1'b1;
          end else begin
            // Length fits in 16 bits here since it is at most max_r.
            left_nxt  = acc_full[15:0] - HDR_BYTES[15:0];
            phase_nxt = PHASE_PAYLOAD;
          end
        end
      end
    end

    if (cfg.valid) begin
      if (cfg.index == REG_BINARY_MODE) begin
        mode_nxt  = cfg.data[0];
        phase_nxt = PHASE_HEADER;
        cnt_nxt   = '0;
        acc_nxt   = '0;
        left_nxt  = '0;
      end else if (cfg.index == REG_MAX_LEN) begin
        max_nxt = cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b1;
      max_r   <= MAX_LEN_RESET;
      phase_r <= PHASE_HEADER;
      cnt_r   <= '0;
      acc_r   <= '0;
      left_r  <= '0;
      err_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      max_r   <= max_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      left_r  <= left_nxt;
      err_r   <= err_nxt;
    end
  end

`include "length_prefixed_stream_deframer_macros.svh"
  `LPSD_ASSERT_NEXT(a_err_sticky, err_r, err_r)
  `LPSD_ASSERT_NOW(a_no_result_after_err, err_r, !res_valid)
  `LPSD_ASSERT_NOW(a_payload_has_bytes, phase_r == PHASE_PAYLOAD, left_r != 16'd0)

endmodule
`default_nettype wire

>>> hw/rtl/lpsd_back.sv
// Back end: result queue and expansion of queued entries into output fields.
`timescale 1ns / 1ps
`default_nettype none
module lpsd_back #(
  parameter int unsigned DEPTH = 4
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  lpsd_pkg::entry_t  wr_entry,
  input  wire               pop,
  output logic              full,
  output logic              empty,
  output logic [7:0]        payload_byte,
  output logic              packet_end,
  output logic              empty_packet,
  output logic              frame_error
);
  import lpsd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = AW + 1;
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  entry_t        mem_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          pop_ok;
  entry_t        head;

  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);
  assign pop_ok = pop && !empty;

  // Wrap at the last entry so any depth works.
  assign wptr_nxt  = !push   ? wptr_r :
                     (wptr_r == LAST_PTR) ? '0 : wptr_r + AW'(1);
  assign rptr_nxt  = !pop_ok ? rptr_r :
                     (rptr_r == LAST_PTR) ? '0 : rptr_r + AW'(1);
  assign count_nxt = count_r + CW'(push) - CW'(pop_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_entry;
    end
  end

  assign head = mem_r[rptr_r];

  always_comb begin
    payload_byte = '0;
    packet_end   = 1'b0;
    empty_packet = 1'b0;
    frame_error  = 1'b0;
    case (head.kind)
      KIND_DATA: begin
        payload_byte = head.data;
        packet_end   = head.last;
      end
      KIND_EMPTY: begin
        packet_end   = 1'b1;
        empty_packet = 1'b1;
      end
      KIND_ERROR: begin
        frame_error  = 1'b1;
      end
      default: begin
        payload_byte = '0;
      end
    endcase
  end

`include "length_prefixed_stream_deframer_macros.svh"
  `LPSD_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `LPSD_ASSERT_NEXT(a_count_up, push && !pop_ok, count_r == $past(count_r) + CW'(1))
  `LPSD_ASSERT_NEXT(a_count_down, pop_ok && !push, count_r == $past(count_r) - CW'(1))

endmodule
`default_nettype wire

>>> hw/rtl/length_prefixed_stream_deframer.sv
// Top level of the length-prefixed stream deframer.
`timescale 1ns / 1ps
`default_nettype none
// Each result is registered into the queue at the clock edge that accepts its byte.
// Throughput: one byte per cycle, sustained while the consumer pops every cycle;
//   the framer holds all per-byte state, and a FIFO_DEPTH-entry queue decouples it.
// full rises only when FIFO_DEPTH results wait; empty falls in the cycle after a result is queued.
// Reset (rst_n low, synchronous) restores binary mode, max length 1024,
//   header phase, clears the sticky error and empties the queue.
module length_prefixed_stream_deframer #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  // Byte input channel
  input  wire         push,
  output logic        full,
  input  wire  [7:0]  in_data_byte,
  // Result channel
  output logic        empty,
  input  wire         pop,
  output logic [7:0]  out_payload_byte,
  output logic        out_packet_end,
  output logic        out_empty_packet,
  output logic        out_frame_error,
  // Configuration write channel
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [7:0]  cfg_index,
  input  wire  [15:0] cfg_data
);
  import lpsd_pkg::*;

  logic    in_accept;
  logic    res_valid;
  entry_t  res;
  cfg_wr_t cfg;

  // Take a byte whenever the queue has room; a byte that gives no result
  // (header byte, or anything after a framing error) still transfers.
  assign in_accept = push && !full;

  // Register writes are always accepted.
  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Front: tracks header/payload phase, assembles the big-endian length,
  // counts payload bytes down and latches framing errors.
  lpsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_byte   (in_data_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // Back: queue the classified results and expand them into output fields.
  lpsd_back #(
    .DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (res_valid),
    .wr_entry     (res),
    .pop          (pop),
    .full         (full),
    .empty        (empty),
    .payload_byte (out_payload_byte),
    .packet_end   (out_packet_end),
    .empty_packet (out_empty_packet),
    .frame_error  (out_frame_error)
  );

endmodule
`default_nettype wire

>>> dv/tb_length_prefixed_stream_deframer.sv
// Self-checking testbench for the length-prefixed stream deframer.
`timescale 1ns / 1ps

module tb_length_prefixed_stream_deframer;
  import lpsd_pkg::*;

  // One result as it leaves the deframer.
  typedef struct packed {
    logic [7:0] payload;
    logic       pkt_end;
    logic       empty_pkt;
    logic       frame_err;
  } frame_res_t;

  // Tracks the deframer's framing state in parallel with the DUT, queues the
  // results that each accepted byte should produce and compares them in order.
  class deframe_scoreboard;
    logic        binary_mode;
    logic [15:0] max_len;
    logic        framing_phase;
    logic [1:0]  hdr_count;
    logic [31:0] len_accum;
    logic [15:0] bytes_left;
    logic        err_latched;
    frame_res_t  expected_q[$];
    int unsigned fails;

    function new();
      binary_mode = 1'b1;
      max_len     = MAX_LEN_RESET;
      err_latched = 1'b0;
      fails       = 0;
      clear_framing();
    endfunction

    function void clear_framing();
      framing_phase = PHASE_HEADER;
      hdr_count     = 2'd0;
      len_accum     = 32'd0;
      bytes_left    = 16'd0;
    endfunction

    function void queue_result(logic [7:0] pb, logic pe, logic ep, logic fe);
      frame_res_t r;
      r.payload   = pb;
      r.pkt_end   = pe;
      r.empty_pkt = ep;
      r.frame_err = fe;
      expected_q.insert(expected_q.size(), r);
    endfunction

    // A mode write restarts framing; the sticky error survives it.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      if (idx == REG_BINARY_MODE) begin
        binary_mode = data[0];
        clear_framing();
      end else if (idx == REG_MAX_LEN) begin
        max_len = data;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      if (err_latched) return;
      if (!binary_mode) begin
        queue_result(b, b == LINE_END, 1'b0, 1'b0);
        return;
      end
      if (framing_phase == PHASE_PAYLOAD) begin
        bytes_left = bytes_left - 16'd1;
        queue_result(b, bytes_left == 16'd0, 1'b0, 1'b0);
        if (bytes_left == 16'd0) clear_framing();
        return;
      end
      len_accum = {len_accum[23:0], b};
      hdr_count = hdr_count + 2'd1;
      if (hdr_count != 2'd0) return;
      if (len_accum > {16'd0, max_len} || len_accum < HDR_BYTES) begin
        err_latched = 1'b1;
        clear_framing();
        queue_result(8'h00, 1'b0, 1'b0, 1'b1);
      end else if (len_accum == HDR_BYTES) begin
        clear_framing();
        queue_result(8'h00, 1'b1, 1'b1, 1'b0);
      end else begin
        bytes_left    = len_accum[15:0] - HDR_BYTES[15:0];
        len_accum     = 32'd0;
        framing_phase = PHASE_PAYLOAD;
      end
    endfunction

    function void check_result(logic [7:0] pb, logic pe, logic ep, logic fe);
      frame_res_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: payload=%02h end=%b empty=%b error=%b",
                 $time, pb, pe, ep, fe);
        fails++;
        return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      if (pb !== want.payload) begin
        $display("%0t: payload_byte mismatch: expected %02h, actual %02h",
                 $time, want.payload, pb);
        fails++;
      end
      if (pe !== want.pkt_end) begin
        $display("%0t: packet_end mismatch: expected %b, actual %b", $time, want.pkt_end, pe);
        fails++;
      end
      if (ep !== want.empty_pkt) begin
        $display("%0t: empty_packet mismatch: expected %b, actual %b",
                 $time, want.empty_pkt, ep);
        fails++;
      end
      if (fe !== want.frame_err) begin
        $display("%0t: frame_error mismatch: expected %b, actual %b",
                 $time, want.frame_err, fe);
        fails++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  localparam int CLK_PERIOD   = 10;
  localparam int STALL_LIMIT  = 5000;  // cycles with no transfer of any kind
  localparam int SETTLE_CYC   = 4;     // margin after the last result is registered
  localparam int PHASE_ITEMS  = 60;
  localparam int RAND_PHASES  = 8;

  // Ways to provoke the single sticky framing error at the end of the run.
  localparam int FAULT_OVERSIZE      = 0;
  localparam int FAULT_SHORT         = 1;
  localparam int FAULT_MAX_BELOW_HDR = 2;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 push         = 1'b0;
  logic [7:0]           in_data_byte = 8'h00;
  logic                 pop          = 1'b0;
  logic                 cfg_valid    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [15:0]          cfg_data     = 16'h0000;
  logic                 full;
  logic                 empty;
  logic [7:0]           out_payload_byte;
  logic                 out_packet_end;
  logic                 out_empty_packet;
  logic                 out_frame_error;
  logic                 cfg_ready;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned stall_cycles   = 0;
  int unsigned items_sent     = 0;

  deframe_scoreboard sb;

  always #(CLK_PERIOD / 2) clk = ~clk;

  length_prefixed_stream_deframer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_data_byte     (in_data_byte),
    .empty            (empty),
    .pop              (pop),
    .out_payload_byte (out_payload_byte),
    .out_packet_end   (out_packet_end),
    .out_empty_packet (out_empty_packet),
    .out_frame_error  (out_frame_error),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // Result side: stall pop at random, re-rolled every falling edge.
  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Sample both transfers at the rising edge in one process. The result is
  // checked before the byte of the same edge is predicted, so a result can
  // never be matched against a byte accepted in the same cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty)
        sb.check_result(out_payload_byte, out_packet_end, out_empty_packet, out_frame_error);
      if (push && !full)
        sb.note_byte(in_data_byte);
    end
  end

  // Watchdog: end the run once nothing has moved on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Drive one byte; enter and leave at a falling edge. Hold push high across
  // back-to-back transfers so the valid never drops and rises in one step.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push         <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (full);
    items_sent++;
    @(negedge clk);
  endtask

  // Send a big-endian length header and random payload, stopping after cut
  // bytes so that a truncated frame can be left behind.
  task automatic send_packet(input logic [31:0] total_len, input int unsigned cut);
    for (int i = 0; i < 4; i++)
      if (i < cut) send_byte(total_len[31 - 8 * i -: 8]);
    for (longint unsigned i = 4; i < total_len && i < cut; i++)
      send_byte(8'($urandom_range(255)));
  endtask

  // Release push, wait for every predicted result, then wait out the SETTLE_CYC
  // margin before anything is reconfigured.
  task automatic settle();
    push <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // One register transfer; valid drops before any next write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(input int unsigned profile);
    case (profile)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
      default: begin send_idle_pct = 23; recv_stall_pct = 23; end
    endcase
  endtask

  initial begin
    logic        bin;
    logic [15:0] max_len;
    logic [31:0] len;
    int unsigned hi;
    int unsigned start;
    int          fault;

    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---------------- directed part ----------------
    // Reset settings: binary framing, max length 1024.
    // Empty packet: a header of exactly four announces no payload.
    send_packet(32'd4, 4);
    // Two payload bytes at the byte extremes, last one marked.
    send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(8'h06);
    send_byte(8'h00); send_byte(8'hff);
    settle();

    // Length equal to the maximum is still accepted.
    write_reg(REG_MAX_LEN, 16'd6);
    send_byte(8'h00); send_byte(8'h00); send_byte(8'h00); send_byte(8'h06);
    send_byte(8'h80); send_byte(8'h7f);
    settle();

    // Text mode: newline ends a line; a max below the header size does not
    // matter here. Writes to indexes past the register list are dropped.
    write_reg(REG_BINARY_MODE, 16'd0);
    write_reg(REG_MAX_LEN, 16'd0);
    write_reg(8'd2, 16'hffff);
    write_reg(8'hff, 16'h0001);
    send_byte(LINE_END); send_byte(8'h00); send_byte(8'hff); send_byte(LINE_END);
    settle();

    // Leave half a header behind, then rewrite the mode: framing must restart,
    // so the next four bytes form an empty packet rather than a bad length.
    write_reg(REG_BINARY_MODE, 16'd1);
    write_reg(REG_MAX_LEN, 16'hffff);
    send_byte(8'h00); send_byte(8'h00);
    settle();
    write_reg(REG_BINARY_MODE, 16'd1);
    send_packet(32'd4, 4);
    settle();

    // ---------------- random part ----------------
    // Phases rotate the idling profile; binary phases carry well-formed
    // frames, text phases carry arbitrary bytes with frequent line ends.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_idling(ph % 4);
      bin = !(ph == 2 || ph == 5);
      if (!bin) begin
        max_len = (ph == 2) ? 16'($urandom_range(3, 0)) : 16'($urandom_range(65535));
      end else if (ph == 0) begin
        max_len = 16'hffff;
      end else if (ph == 1) begin
        max_len = HDR_BYTES[15:0];
      end else begin
        case ($urandom_range(2))
          0:       max_len = 16'($urandom_range(64, 5));
          1:       max_len = MAX_LEN_RESET;
          default: max_len = 16'($urandom_range(65535, 4));
        endcase
      end
      write_reg(REG_BINARY_MODE, {15'd0, bin});
      write_reg(REG_MAX_LEN, max_len);
      if ($urandom_range(1))
        write_reg(CFG_IDX_W'($urandom_range(255, 2)), 16'($urandom_range(65535)));

      start = items_sent;
      hi    = (max_len < 40) ? max_len : 40;
      while (items_sent - start < PHASE_ITEMS) begin
        if (!bin) begin
          send_byte(($urandom_range(99) < 15) ? LINE_END : 8'($urandom_range(255)));
        end else begin
          // Mostly short frames; now and then one at the maximum or, for a large maximum, of 41 to 300 bytes.
          if ($urandom_range(9) == 0)
            len = (max_len <= 300) ? max_len : $urandom_range(300, 41);
          else
            len = $urandom_range(hi, 4);
          send_packet(len, len);
        end
      end
      // Broken frame: cut off inside header or payload; the next mode write
      // must discard it.
      if (bin && $urandom_range(1)) begin
        len = $urandom_range(hi, 4);
        send_packet(len, $urandom_range(len - 1, 1));
      end
      settle();
    end

    // ---------------- sticky error ----------------
    // The error latches until reset, so it can be provoked only once, last.
    set_idling(3);
    fault   = $urandom_range(FAULT_MAX_BELOW_HDR, FAULT_OVERSIZE);
    max_len = 16'($urandom_range(1023, 4));
    case (fault)
      FAULT_OVERSIZE:
        len = $urandom_range(1) ? ({$urandom} | 32'h8000_0000) : {16'd0, max_len} + 32'd1;
      FAULT_SHORT:
        len = $urandom_range(3, 0);
      default: begin
        max_len = 16'($urandom_range(3, 0));
        len     = $urandom_range(64, 4);
      end
    endcase
    write_reg(REG_BINARY_MODE, 16'd1);
    write_reg(REG_MAX_LEN, max_len);
    send_packet(len, 4);
    // Everything after the error is dropped, in either mode.
    repeat (8) send_byte(8'($urandom_range(255)));
    settle();
    write_reg(REG_BINARY_MODE, 16'd0);
    repeat (4) send_byte(8'($urandom_range(255)));
    send_byte(LINE_END);

    // Drain with the receiver always ready, then watch for stray results.
    set_idling(0);
    settle();
    repeat (20) @(negedge clk);
    if (sb.fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
